// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared constants, field widths and types for the text console writer.
// No dependencies; every other file of the block except tcw_ram imports it.

package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed field widths of the request and response channels
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ATTR_W    = 8;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Control characters and attribute after reset
    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

    // One screen cell as stored in the memory
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] code;
    } cell_t;

    // What a put needs beyond the cursor update
    typedef struct packed {
        logic scroll;   // scroll the screen up one row first
        logic write;    // store a printable character
    } put_flags_t;

    typedef enum logic [2:0] {
        ST_INIT,    // clearing pass after reset
        ST_IDLE,
        ST_READ,    // cell read in flight
        ST_CLEAR,   // blank every cell
        ST_COPY,    // scroll: move rows up
        ST_BLANK,   // scroll: blank bottom row
        ST_WRITE,   // store the character
        ST_DONE     // hand the result to the output register
    } state_t;

endpackage

// File: hw/rtl/tcw_if.sv
`timescale 1ns / 1ps
// tcw_req_if / tcw_rsp_if: valid/ready channels of the text console writer.
// Depends on tcw_pkg for field widths.

interface tcw_req_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [CHAR_W-1:0]    character;
    logic [INDEX_W-1:0]   cell_index;

    modport source (output valid, operation, character, cell_index, input ready);
    modport sink   (input valid, operation, character, cell_index, output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;

    modport source (output valid, cell_char, cell_attr, cursor_row, cursor_column,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_column,
                    output ready);
endinterface

// File: hw/rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// text_console_writer_core: top level of the text console writer.
// Depends on tcw_pkg, tcw_if, tcw_ram and tcw_put_plan.
//
// Usage
//   cmd (sink): one request per valid/ready handshake: put a character, read a
//   cell, or clear the screen. rsp (source): exactly one response per request,
//   carrying the read cell (zero for other operations) and the cursor after it.
//   attr_we/attr_wdata write the attribute byte used for characters and blanks;
//   write it only while no request is outstanding.
// Operation
//   The screen lives in one ROWS*COLUMNS entry RAM with a registered read port.
//   A printable put without scroll passes ST_WRITE and a read ST_READ before
//   ST_DONE; newline and carriage return without scroll and the unused code go straight to ST_DONE.
//   A scroll copies the rows up through the RAM read port, then blanks the
//   bottom row; a clear blanks every cell. Both walk the
//   RAM one cell per cycle, bounded by its single write port.
// Reset
//   After rst_n releases, a clearing pass sets all ROWS*COLUMNS cells (2000 at
//   the default size) to char 0 / attribute 15; cmd.ready stays low meanwhile
//   and until the last store has landed.
//   Attribute writes are taken at any time.
// Stall
//   The response sits in an output register; a new request is taken while it
//   waits, and the next response is held back until rsp.ready drains it.

module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tcw_req_if.sink                     cmd,
    tcw_rsp_if.source                   rsp,
    input  logic                        attr_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr_wdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $bits(cell_t);

    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_OFS   = AW'(COLUMNS);

    // control state
    state_t             state_reg, state_next;
    logic [AW-1:0]      ptr_reg, ptr_next;          // sweep pointer
    logic [ATTR_W-1:0]  attr_reg;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic               write_pend_reg, write_pend_next;
    logic               read_ok_reg, read_ok_next;

    // pending character store
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [CHAR_W-1:0]  char_reg, char_next;

    // result of the current request
    cell_t              res_reg, res_next;

    // write stage in front of the RAM: every store goes through it
    logic               pipe_valid_reg, pipe_valid_next;
    logic               pipe_from_ram_reg, pipe_from_ram_next;
    logic [AW-1:0]      pipe_addr_reg, pipe_addr_next;
    cell_t              pipe_data_reg, pipe_data_next;

    // output register
    logic               out_valid_reg;
    cell_t              out_cell_reg;
    logic [RW-1:0]      out_row_reg;
    logic [CW-1:0]      out_col_reg;
    logic               load_out;

    // RAM ports
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_rdata;
    logic [DW-1:0]      ram_wdata;
    cell_t              rd_cell;

    // put planner
    put_flags_t         plan_flags;
    logic [RW-1:0]      plan_row;
    logic [CW-1:0]      plan_col;
    logic [AW-1:0]      plan_addr;

    logic               cmd_accept;

    tcw_put_plan #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_plan (
        .row      (row_reg),
        .col      (col_reg),
        .code     (cmd.character),
        .flags    (plan_flags),
        .row_next (plan_row),
        .col_next (plan_col),
        .addr     (plan_addr)
    );

    tcw_ram #(
        .WIDTH (DW),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (pipe_valid_reg),
        .waddr (pipe_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_cell   = cell_t'(ram_rdata);
    assign ram_wdata = pipe_from_ram_reg ? ram_rdata : DW'(pipe_data_reg);

    // hold requests off while a store is still landing, so a read never
    // meets a write to the same cell
    assign cmd.ready  = (state_reg == ST_IDLE) && !pipe_valid_reg;
    assign cmd_accept = cmd.valid && cmd.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_char     = out_cell_reg.code;
    assign rsp.cell_attr     = out_cell_reg.attr;
    assign rsp.cursor_row    = ROW_OUT_W'(out_row_reg);
    assign rsp.cursor_column = COL_OUT_W'(out_col_reg);

    always_comb
    begin
        state_next         = state_reg;
        ptr_next           = ptr_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        write_pend_next    = write_pend_reg;
        read_ok_next       = read_ok_reg;
        wr_addr_next       = wr_addr_reg;
        char_next          = char_reg;
        res_next           = res_reg;
        pipe_valid_next    = 1'b0;
        pipe_from_ram_next = 1'b0;
        pipe_addr_next     = ptr_reg;
        pipe_data_next     = '{attr: attr_reg, code: '0};
        ram_re             = 1'b0;
        ram_raddr          = ptr_reg + ROW_OFS;
        load_out           = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                pipe_valid_next = 1'b1;
                pipe_data_next  = '{attr: RESET_ATTR, code: '0};
                if (ptr_reg == CELL_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    res_next = '0;
                    ptr_next = '0;
                    case (cmd.operation)
                        OP_PUT:
                        begin
                            row_next        = plan_row;
                            col_next        = plan_col;
                            wr_addr_next    = plan_addr;
                            char_next       = cmd.character;
                            write_pend_next = plan_flags.write;
                            if (plan_flags.scroll)
                            begin
                                state_next = ST_COPY;
                            end
                            else if (plan_flags.write)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = AW'(cmd.cell_index);
                            read_ok_next = (32'(cmd.cell_index) < 32'(CELLS));
                            state_next   = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_next   = read_ok_reg ? rd_cell : '0;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                pipe_valid_next = 1'b1;
                if (ptr_reg == CELL_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_COPY:
            begin
                // read the cell one row below, store it in the next cycle
                ram_re             = 1'b1;
                pipe_valid_next    = 1'b1;
                pipe_from_ram_next = 1'b1;
                ptr_next           = ptr_reg + 1'b1;
                if (ptr_reg == COPY_LAST)
                begin
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                pipe_valid_next = 1'b1;
                if (ptr_reg == CELL_LAST)
                begin
                    state_next = write_pend_reg ? ST_WRITE : ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_WRITE:
            begin
                pipe_valid_next = 1'b1;
                pipe_addr_next  = wr_addr_reg;
                pipe_data_next  = '{attr: attr_reg, code: char_reg};
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            ptr_reg        <= '0;
            attr_reg       <= RESET_ATTR;
            row_reg        <= '0;
            col_reg        <= '0;
            write_pend_reg <= 1'b0;
            read_ok_reg    <= 1'b0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            write_pend_reg <= write_pend_next;
            read_ok_reg    <= read_ok_next;
            pipe_valid_reg <= pipe_valid_next;
            if (attr_we)
            begin
                attr_reg <= attr_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg       <= wr_addr_next;
        char_reg          <= char_next;
        res_reg           <= res_next;
        pipe_from_ram_reg <= pipe_from_ram_next;
        pipe_addr_reg     <= pipe_addr_next;
        pipe_data_reg     <= pipe_data_next;
        if (load_out)
        begin
            out_cell_reg <= res_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
        end
    end

    // stores stay inside the screen
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (32'(pipe_addr_reg) < 32'(CELLS)))
        else $error("screen store address out of range");

    // no read and write of the same cell in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && pipe_valid_reg) |-> (ram_raddr != pipe_addr_reg))
        else $error("read and write hit the same cell");

    // cursor never runs beyond its pending positions
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) <= 32'(ROWS)) && (32'(col_reg) <= 32'(COLUMNS)))
        else $error("cursor out of bounds");

    // a response is produced only from the hand-off state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (state_reg == ST_DONE))
        else $error("response loaded outside hand-off");

    // no request is taken while a store is still landing
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> !$past(pipe_valid_reg))
        else $error("request accepted with a store in flight");

endmodule

// File: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
// tcw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/tcw_put_plan.sv
`timescale 1ns / 1ps
// tcw_put_plan: works out the cursor move, scroll and cell address of one put.
// Depends on tcw_pkg.

module tcw_put_plan #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int RW     = $clog2(ROWS + 1),
    localparam int CW     = $clog2(COLUMNS + 1),
    localparam int AW     = $clog2(ROWS * COLUMNS)
) (
    input  logic [RW-1:0]               row,
    input  logic [CW-1:0]               col,
    input  logic [tcw_pkg::CHAR_W-1:0]  code,
    output tcw_pkg::put_flags_t         flags,
    output logic [RW-1:0]               row_next,
    output logic [CW-1:0]               col_next,
    output logic [AW-1:0]               addr
);
    import tcw_pkg::*;

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_END  = RW'(ROWS);
    localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);

    logic          pend;
    logic [RW-1:0] r0;
    logic [CW-1:0] c0;
    logic [RW-1:0] rw;
    logic [CW-1:0] cw;

    always_comb
    begin
        // a row past the bottom means a scroll is owed before anything else
        pend         = (row >= ROW_END);
        r0           = pend ? ROW_LAST : row;
        c0           = pend ? '0 : col;
        rw           = r0;
        cw           = c0;
        flags.scroll = pend;
        flags.write  = 1'b0;
        row_next     = r0;
        col_next     = '0;

        if (code == CODE_NEWLINE)
        begin
            row_next = r0 + 1'b1;
        end
        else if (code != CODE_RETURN)
        begin
            // wrap at the right edge, scroll when the wrap leaves the screen
            if (c0 >= COL_END)
            begin
                cw = '0;
                rw = r0 + 1'b1;
                if (rw >= ROW_END)
                begin
                    rw           = ROW_LAST;
                    flags.scroll = 1'b1;
                end
            end
            flags.write = 1'b1;
            row_next    = rw;
            col_next    = cw + 1'b1;
        end

        addr = AW'(AW'(rw) * AW'(COLUMNS)) + AW'(cw);
    end

endmodule
